>>> src/homogeneous_point_transform_assert.svh
// assertion helpers for the rtl, included by homogeneous_point_transform.sv
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// checked only outside reset
`define HPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/hpt_pkg.sv
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int COEF_W = 32;
  localparam int NUM_REGS = 8;
  localparam int REG_AW = 3;

  typedef enum logic [REG_AW-1:0] {
    REG_ROW0_COLS01,
    REG_ROW0_COLS23,
    REG_ROW1_COLS01,
    REG_ROW1_COLS23,
    REG_ROW2_COLS01,
    REG_ROW2_COLS23,
    REG_ROW3_COLS01,
    REG_ROW3_COLS23
  } reg_idx_t;

endpackage

>>> src/homogeneous_point_transform.sv
`timescale 1ns / 1ps
// Homogeneous 4x4 point transform with perspective divide.
// Input stream (s_*): one point per transfer, tdata = {point_z, point_y, point_x},
// signed fixed point with FRAC_BITS fractional bits. Output stream (m_*): one
// result per point, tdata = {result_z, result_y, result_x}, tuser = {saturated,
// w_was_zero}. The matrix sits in eight 64-bit registers on the APB port at
// byte address 8*i, two coefficients each, first in the low half; write it
// only while no point is in flight.
// The pipeline holds COORD_WIDTH + 6 register stages: one stage of multipliers
// (loaded at the input transfer), two adder stages, a sign/magnitude stage, an
// overflow compare stage, one restoring divide stage per quotient bit (all three
// coordinates in parallel) and the output register. While the receiver keeps up,
// a point can enter every cycle, so throughput is one point per cycle.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls, each stage holds only while the one after it is
// full, so bubbles are squeezed out and the input keeps taking points until
// the whole pipeline is full.
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // point_x, point_y, point_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // result_x, result_y, result_z
  output logic [1:0]   m_tuser,   // w_was_zero, saturated
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

`include "homogeneous_point_transform_assert.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int PTW = (CW > FRAC_BITS + 2) ? CW : FRAC_BITS + 2;
  localparam int PW  = COEF_W + PTW;
  localparam int SW  = PW + 2;
  localparam int DW  = SW;
  localparam int NX  = SW + FRAC_BITS + CW;
  localparam int L   = CW + 6;
  localparam int ST_D0 = 5;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = 64'(1) << (FRAC_BITS + 32);

  // configuration registers
  logic [63:0] cfg_regs [NUM_REGS];
  logic [REG_AW-1:0] cfg_idx;

  assign cfg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign prdata  = cfg_regs[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[REG_ROW0_COLS01] <= ONE_LO;
      cfg_regs[REG_ROW0_COLS23] <= '0;
      cfg_regs[REG_ROW1_COLS01] <= ONE_HI;
      cfg_regs[REG_ROW1_COLS23] <= '0;
      cfg_regs[REG_ROW2_COLS01] <= '0;
      cfg_regs[REG_ROW2_COLS23] <= ONE_LO;
      cfg_regs[REG_ROW3_COLS01] <= '0;
      cfg_regs[REG_ROW3_COLS23] <= ONE_HI;
    end else if (psel && penable && pwrite && pready) begin
      cfg_regs[cfg_idx] <= pwdata;
    end
  end

  // pipeline control: a stage loads when empty or when the next one moves
  logic [L-1:0] vld;
  logic [L-1:0] ce;

  always_comb begin
    ce[L-1] = !vld[L-1] || m_tready;
    for (int k = L - 2; k >= 0; k--) ce[k] = !vld[k] || ce[k+1];
  end

  assign s_tready = ce[0];
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < L; k++) begin
        if (ce[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: sixteen products
  logic signed [PTW-1:0]    pt [4];
  logic signed [COEF_W-1:0] coef [4][4];
  logic signed [PW-1:0]     prod [4][4];

  always_comb begin
    for (int c = 0; c < 3; c++) pt[c] = PTW'($signed(s_tdata[c*32 +: CW]));
    pt[3] = PTW'(ONE_LO);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = $signed(cfg_regs[r*2 + c/2][(c%2)*32 +: 32]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) prod[r][c] <= PW'(coef[r][c] * pt[c]);
      end
    end
  end

  // stage 1: pair sums
  logic signed [PW:0] pair_a [4];
  logic signed [PW:0] pair_b [4];

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      for (int r = 0; r < 4; r++) begin
        pair_a[r] <= (PW+1)'(prod[r][0]) + (PW+1)'(prod[r][1]);
        pair_b[r] <= (PW+1)'(prod[r][2]) + (PW+1)'(prod[r][3]);
      end
    end
  end

  // stage 2: row sums
  logic signed [SW-1:0] row_sum [4];

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      for (int r = 0; r < 4; r++) row_sum[r] <= SW'(pair_a[r]) + SW'(pair_b[r]);
    end
  end

  // stage 3: sign and magnitude
  logic [DW-1:0] m_mag [3];
  logic          m_neg [3];
  logic [DW-1:0] m_div;
  logic          m_wz;

  always_ff @(posedge clk) begin
    if (ce[3]) begin
      for (int i = 0; i < 3; i++) begin
        m_mag[i] <= row_sum[i][SW-1] ? DW'(-row_sum[i]) : DW'(row_sum[i]);
        m_neg[i] <= row_sum[i][SW-1] ^ row_sum[3][SW-1];
      end
      m_div <= row_sum[3][SW-1] ? DW'(-row_sum[3]) : DW'(row_sum[3]);
      m_wz  <= (row_sum[3] == '0);
    end
  end

  // stage 4: scale numerator, catch quotients of CW bits or more
  logic [NX-1:0] num_x [3];
  logic [NX-1:0] div_x;
  logic [DW-1:0] n_rem [3];
  logic [CW-1:0] n_lo [3];
  logic          n_neg [3];
  logic          n_ovf [3];
  logic [DW-1:0] n_div;
  logic          n_wz;

  always_comb begin
    for (int i = 0; i < 3; i++) num_x[i] = NX'(m_mag[i]) << FRAC_BITS;
    div_x = NX'(m_div) << CW;
  end

  always_ff @(posedge clk) begin
    if (ce[4]) begin
      for (int i = 0; i < 3; i++) begin
        n_rem[i] <= num_x[i][CW +: DW];
        n_lo[i]  <= num_x[i][CW-1:0];
        n_neg[i] <= m_neg[i];
        n_ovf[i] <= (num_x[i] >= div_x);
      end
      n_div <= m_div;
      n_wz  <= m_wz;
    end
  end

  // restoring divide, one quotient bit per stage
  logic [DW-1:0] d_rem [CW][3];
  logic [CW-1:0] d_q   [CW][3];
  logic [CW-1:0] d_lo  [CW][3];
  logic          d_neg [CW][3];
  logic          d_ovf [CW][3];
  logic [DW-1:0] d_div [CW];
  logic          d_wz  [CW];

  for (genvar j = 0; j < CW; j++) begin : g_div
    logic [DW-1:0] src_rem [3];
    logic [CW-1:0] src_q   [3];
    logic [CW-1:0] src_lo  [3];
    logic          src_neg [3];
    logic          src_ovf [3];
    logic [DW-1:0] src_div;
    logic          src_wz;
    logic [DW:0]   trial   [3];
    logic          ge      [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          src_rem[i] = n_rem[i];
          src_q[i]   = '0;
          src_lo[i]  = n_lo[i];
          src_neg[i] = n_neg[i];
          src_ovf[i] = n_ovf[i];
        end else begin
          src_rem[i] = d_rem[(j == 0) ? 0 : j-1][i];
          src_q[i]   = d_q[(j == 0) ? 0 : j-1][i];
          src_lo[i]  = d_lo[(j == 0) ? 0 : j-1][i];
          src_neg[i] = d_neg[(j == 0) ? 0 : j-1][i];
          src_ovf[i] = d_ovf[(j == 0) ? 0 : j-1][i];
        end
        trial[i] = {src_rem[i], src_lo[i][CW-1]};
      end
      if (j == 0) begin
        src_div = n_div;
        src_wz  = n_wz;
      end else begin
        src_div = d_div[(j == 0) ? 0 : j-1];
        src_wz  = d_wz[(j == 0) ? 0 : j-1];
      end
      for (int i = 0; i < 3; i++) ge[i] = (trial[i] >= {1'b0, src_div});
    end

    always_ff @(posedge clk) begin
      if (ce[ST_D0 + j]) begin
        for (int i = 0; i < 3; i++) begin
          d_rem[j][i] <= ge[i] ? DW'(trial[i] - {1'b0, src_div}) : trial[i][DW-1:0];
          d_q[j][i]   <= {src_q[i][CW-2:0], ge[i]};
          d_lo[j][i]  <= src_lo[i] << 1;
          d_neg[j][i] <= src_neg[i];
          d_ovf[j][i] <= src_ovf[i];
        end
        d_div[j] <= src_div;
        d_wz[j]  <= src_wz;
      end
    end
  end

  // output stage: saturate, apply sign, zero data and w_was_zero when w is zero
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] fin_val [3];
  logic          fin_sat [3];
  logic [95:0]   o_data;
  logic [1:0]    o_user;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_sat[i] = d_ovf[CW-1][i] ||
                   (d_q[CW-1][i] > (d_neg[CW-1][i] ? NEG_MIN : POS_MAX));
      if (fin_sat[i]) fin_val[i] = d_neg[CW-1][i] ? NEG_MIN : POS_MAX;
      else if (d_neg[CW-1][i]) fin_val[i] = -d_q[CW-1][i];
      else fin_val[i] = d_q[CW-1][i];
    end
  end

  always_ff @(posedge clk) begin
    if (ce[L-1]) begin
      if (d_wz[CW-1]) begin
        o_data <= '0;
        o_user <= 2'b01;
      end else begin
        for (int i = 0; i < 3; i++) o_data[i*32 +: 32] <= 32'($signed(fin_val[i]));
        o_user <= {fin_sat[0] || fin_sat[1] || fin_sat[2], 1'b0};
      end
    end
  end

  assign m_tdata = o_data;
  assign m_tuser = o_user;

  `HPT_ASSERT(a_zero_w_no_sat, m_tvalid && m_tuser[0] |-> !m_tuser[1], "w zero with saturation")
  `HPT_ASSERT(a_zero_w_data, m_tvalid && m_tuser[0] |-> m_tdata == '0, "w zero with nonzero data")
  `HPT_ASSERT(a_full_stall, !s_tready |-> m_tvalid && !m_tready, "input stalled without full pipe")
  `HPT_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

>>> verif/tb_homogeneous_point_transform.sv
`timescale 1ns / 1ps
module tb_homogeneous_point_transform;
  import hpt_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 32 + 6;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic        wzero;
    logic        sat;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  homogeneous_point_transform u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] matrix_regs [NUM_REGS];
  point_t pending_points[$];
  proj_t expected_proj[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  bit in_fire = 1'b0;

  function automatic logic signed [31:0] coef(int row, int col);
    logic [63:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic [31:0] divide_sat(logic signed [127:0] num,
                                             logic signed [127:0] w, ref bit sat);
    logic [127:0] nm, wm, q;
    logic [127:0] limit;
    bit neg;
    neg = num[127] ^ w[127];
    nm = num[127] ? -num : num;
    wm = w[127] ? -w : w;
    q = (nm << FRAC) / wm;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > limit) begin
      sat = 1'b1;
      q = limit;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic proj_t project_point(point_t p);
    logic signed [127:0] sums [4];
    logic signed [127:0] v [4];
    proj_t e;
    bit sat;
    sat = 1'b0;
    v[0] = $signed(p.x);
    v[1] = $signed(p.y);
    v[2] = $signed(p.z);
    v[3] = 128'sd1 << FRAC;
    for (int r = 0; r < 4; r++) begin
      sums[r] = '0;
      for (int c = 0; c < 4; c++) sums[r] += 128'(coef(r, c)) * v[c];
    end
    e = '0;
    if (sums[3] == 0) begin
      e.wzero = 1'b1;
      return e;
    end
    e.rx = divide_sat(sums[0], sums[3], sat);
    e.ry = divide_sat(sums[1], sums[3], sat);
    e.rz = divide_sat(sums[2], sums[3], sat);
    e.sat = sat;
    return e;
  endfunction

  // input transfers are taken at the rising edge
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      in_fire = 1'b1;
      expected_proj.push_back(project_point(point_t'(s_tdata)));
      void'(pending_points.pop_front());
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_fire) begin
        if (pending_points.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 7)) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_points[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || $urandom_range(99) >= 7;
    end
  end

  // monitor
  always @(posedge clk) begin
    proj_t got, e;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0], m_tuser[1]};
      if (expected_proj.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, got);
        errors++;
      end else begin
        e = expected_proj.pop_front();
        if (got.rx !== e.rx) begin
          $display("%0t: result_x exp %h got %h", $time, e.rx, got.rx);
          errors++;
        end
        if (got.ry !== e.ry) begin
          $display("%0t: result_y exp %h got %h", $time, e.ry, got.ry);
          errors++;
        end
        if (got.rz !== e.rz) begin
          $display("%0t: result_z exp %h got %h", $time, e.rz, got.rz);
          errors++;
        end
        if (got.wzero !== e.wzero) begin
          $display("%0t: w_was_zero exp %b got %b", $time, e.wzero, got.wzero);
          errors++;
        end
        if (got.sat !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, got.sat);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    matrix_regs[idx] = value;
  endtask

  task automatic drain();
    wait (pending_points.size() == 0 && !s_tvalid && expected_proj.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(6))
      0: return 32'h0001_0000;
      1: return 32'h0;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  task automatic load_matrix(int mode);
    for (int i = 0; i < NUM_REGS; i++) begin
      logic [63:0] v;
      case (mode)
        0: v = {rand_coef(), rand_coef()};
        1: v = '1;
        2: v = {32'h7fff_ffff, 32'h8000_0000};
        default: v = {$urandom, $urandom};
      endcase
      // keep w usually nonzero-ish in random mode: the row 3, column 3 coefficient gets a sane value
      if (mode == 0 && i == 7 && $urandom_range(3) != 0)
        v = {32'(32'h0001_0000 + $urandom_range(0, 32'h0002_0000)), v[31:0]};
      apb_write(reg_idx_t'(i), v);
    end
  endtask

  initial begin
    matrix_regs[0] = 64'h0000_0000_0001_0000;
    matrix_regs[1] = 64'h0;
    matrix_regs[2] = 64'h0001_0000_0000_0000;
    matrix_regs[3] = 64'h0;
    matrix_regs[4] = 64'h0;
    matrix_regs[5] = 64'h0000_0000_0001_0000;
    matrix_regs[6] = 64'h0;
    matrix_regs[7] = 64'h0001_0000_0000_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // identity: extremes pass straight through
    push_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    push_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    push_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
    push_point($urandom, $urandom, $urandom);
    drain();

    // w depends on z: zero w, tiny w (saturation) and negative w
    apb_write(REG_ROW3_COLS23, {32'h0, 32'h0001_0000});
    push_point(32'h0001_0000, 32'h0002_0000, 32'h0);
    push_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    push_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    push_point(32'h0003_0000, 32'hfffd_0000, 32'hfffe_0000);
    push_point(32'h0003_0000, 32'h0005_0000, 32'h0002_0000);
    drain();

    // all-ones and extreme matrices
    load_matrix(1);
    push_point(32'h0, 32'h0, 32'h0);
    push_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    load_matrix(2);
    push_point(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
    push_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    push_point(32'h0, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      load_matrix(ph % 3 == 2 ? 3 : 0);
      calm = (ph == 4);
      for (int n = 0; n < 150; n++) begin
        push_point(rand_coord(), rand_coord(), rand_coord());
        if (ph == 6 && n == 75) begin
          wait (pending_points.size() == 0 && expected_proj.size() == 0);
        end
      end
      if (ph == 6) begin
        hold_off = 1'b1;
        wait (expected_proj.size() == 0);
        hold_off = 1'b0;
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("[homogeneous_point_transform] OK");
    end else begin
      $display("[homogeneous_point_transform] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[homogeneous_point_transform] ERROR");
    $finish;
  end

endmodule
